>>> rtl/ntc_lin_pkg.sv
// Package for the NTC thermistor linearizer: resistance table, status codes, widths.
// No dependencies; used by ntc_thermistor_linearizer_unit.
package ntc_lin_pkg;

  // entries physically held in the resistance table
  localparam int unsigned TabStored = 31;
  localparam int unsigned TabW      = 19;   // 326500 tenths fits 19 bits
  localparam int unsigned ResW      = 24;   // saturated resistance width
  localparam logic [ResW-1:0] ResMax = {ResW{1'b1}};
  localparam int unsigned StepCenti = 500;  // 5 degrees in hundredths
  localparam logic signed [14:0] ColdCenti = -15'sd1000;
  localparam logic signed [14:0] HotCenti  = 15'sd16000;

  // range status codes
  localparam logic [1:0] StInterp = 2'd0;
  localparam logic [1:0] StCold   = 2'd1;
  localparam logic [1:0] StHot    = 2'd2;

  // resistance in tenths of an ohm, 0 to 150 degC in 5 degC steps
  function automatic logic [TabW-1:0] tab_f(input logic [4:0] idx);
    logic [TabW-1:0] v;
    case (idx)
      5'd0:  v = 19'd326500;
      5'd1:  v = 19'd253900;
      5'd2:  v = 19'd199000;
      5'd3:  v = 19'd157100;
      5'd4:  v = 19'd124900;
      5'd5:  v = 19'd100000;
      5'd6:  v = 19'd80570;
      5'd7:  v = 19'd65310;
      5'd8:  v = 19'd53270;
      5'd9:  v = 19'd43690;
      5'd10: v = 19'd36030;
      5'd11: v = 19'd29860;
      5'd12: v = 19'd24880;
      5'd13: v = 19'd20830;
      5'd14: v = 19'd17520;
      5'd15: v = 19'd14810;
      5'd16: v = 19'd12580;
      5'd17: v = 19'd10720;
      5'd18: v = 19'd9177;
      5'd19: v = 19'd7885;
      5'd20: v = 19'd6800;
      5'd21: v = 19'd5886;
      5'd22: v = 19'd5112;
      5'd23: v = 19'd4454;
      5'd24: v = 19'd3893;
      5'd25: v = 19'd3417;
      5'd26: v = 19'd3009;
      5'd27: v = 19'd2654;
      5'd28: v = 19'd2348;
      5'd29: v = 19'd2083;
      5'd30: v = 19'd1853;
      default: v = 19'd0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/ntc_thermistor_linearizer_unit.sv
// Top level of the NTC thermistor linearizer: APB register, divider pipelines, table interpolation.
// Depends on ntc_lin_pkg.

// Converts one 12-bit ADC code per word into a temperature in hundredths of a degree
// with a range status. The block is a fixed pipeline of 49 register stages: one
// multiply, one times-ten stage, a 32-stage one-bit-per-stage divider for the
// resistance, a table compare stage, an index stage, an interpolation set-up of three
// stages, a 9-stage divider for the fraction and an output register. A new word
// may enter every cycle unless the output stalls, so throughput is one word per
// cycle; the accepting edge loads the first stage. A stall at the output freezes
// the whole pipeline. pullup_ohms sits at byte address 0 and resets to 8200.
module ntc_thermistor_linearizer_unit #(
  parameter int unsigned TABLE_ENTRIES = 31
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // APB configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [11:0]        adc_code_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [14:0] temp_centideg_o,
  output logic [1:0]         range_status_o
);

  localparam int unsigned NUsed = (TABLE_ENTRIES > ntc_lin_pkg::TabStored) ?
                                  ntc_lin_pkg::TabStored : TABLE_ENTRIES;
  localparam int unsigned IdxW  = $clog2(NUsed + 1);
  localparam int unsigned Div1N = 32;
  localparam int unsigned Div2N = 9;
  localparam int unsigned ResW  = ntc_lin_pkg::ResW;

  // configuration register
  logic [15:0] pullup_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {16'd0, pullup_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pullup_q <= 16'd8200;
    end else if (cfg_wr) begin
      pullup_q <= pwdata[15:0];
    end
  end

  // pipeline advance: whole pipe moves unless the output word is held
  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // stage 1: code times pullup
  logic        v1_q;
  logic [27:0] prod1_q;
  logic [12:0] den1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod1_q <= 28'(adc_code_i) * 28'(pullup_q);
      den1_q  <= 13'd4096 - 13'(adc_code_i);
    end
  end

  // stage 2 feeds the resistance divider: numerator times ten
  logic        dv_q  [Div1N+1];
  logic [31:0] dw_q  [Div1N+1];   // numerator shifts out at the top, quotient in
  logic [12:0] rem_q [Div1N+1];
  logic [12:0] den_q [Div1N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (en) begin
      dv_q[0] <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dw_q[0]  <= {prod1_q, 3'b000} + {3'b000, prod1_q, 1'b0};
      rem_q[0] <= 13'd0;
      den_q[0] <= den1_q;
    end
  end

  // resistance divider, one quotient bit per stage
  for (genvar k = 0; k < Div1N; k++) begin : g_div1
    logic [13:0] trial;
    logic        take;
    assign trial = {rem_q[k], dw_q[k][31]};
    assign take  = trial >= {1'b0, den_q[k]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k+1] <= 1'b0;
      end else if (en) begin
        dv_q[k+1] <= dv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_q[k+1] <= take ? 13'(trial - {1'b0, den_q[k]}) : trial[12:0];
        dw_q[k+1]  <= {dw_q[k][30:0], take};
        den_q[k+1] <= den_q[k];
      end
    end
  end

  // stage 3: saturate and compare against every used entry
  logic [ResW-1:0] r_sat;
  logic [NUsed-1:0] gt_d;
  logic            v3_q;
  logic [ResW-1:0] r3_q;
  logic [NUsed-1:0] gt3_q;

  assign r_sat = (|dw_q[Div1N][31:ResW]) ? ntc_lin_pkg::ResMax : dw_q[Div1N][ResW-1:0];

  always_comb begin
    for (int j = 0; j < NUsed; j++) begin
      gt_d[j] = {5'd0, ntc_lin_pkg::tab_f(5'(j))} > r_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= dv_q[Div1N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r3_q  <= r_sat;
      gt3_q <= gt_d;
    end
  end

  // stage 4: index = count of entries above the resistance (table is monotonic)
  logic            v4_q;
  logic [ResW-1:0] r4_q;
  logic [IdxW-1:0] i4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r4_q <= r3_q;
      i4_q <= IdxW'($countones(gt3_q));
    end
  end

  // stage 5: range status, segment width and offset into the segment
  logic [1:0]            st_d;
  logic [ntc_lin_pkg::TabW-1:0] hi_v, lo_v;
  logic                  v5_q;
  logic [1:0]            st5_q;
  logic [IdxW-1:0]       i5_q;
  logic [16:0]           d5_q, df5_q;

  assign hi_v = ntc_lin_pkg::tab_f(5'(i4_q - 1'b1));
  assign lo_v = ntc_lin_pkg::tab_f(5'(i4_q));

  always_comb begin
    if (i4_q == '0) begin
      st_d = ntc_lin_pkg::StCold;
    end else if (32'(i4_q) >= NUsed) begin
      st_d = ntc_lin_pkg::StHot;
    end else begin
      st_d = ntc_lin_pkg::StInterp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st5_q <= st_d;
      i5_q  <= i4_q;
      d5_q  <= 17'(hi_v - lo_v);
      df5_q <= 17'(r4_q - {5'd0, lo_v});
    end
  end

  // stage 6: scale offset by one step
  logic            v6_q;
  logic [1:0]      st6_q;
  logic [IdxW-1:0] i6_q;
  logic [16:0]     d6_q;
  logic [25:0]     n6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (en) begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st6_q <= st5_q;
      i6_q  <= i5_q;
      d6_q  <= d5_q;
      n6_q  <= 26'(df5_q) * 26'(ntc_lin_pkg::StepCenti);
    end
  end

  // stage 7: rounding numerator and doubled divisor
  logic            fv_q  [Div2N+1];
  logic [1:0]      fst_q [Div2N+1];
  logic [IdxW-1:0] fi_q  [Div2N+1];
  logic [26:0]     fnr_q [Div2N+1];
  logic [17:0]     fdv_q [Div2N+1];
  logic [Div2N-1:0] fq_q [Div2N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q[0] <= 1'b0;
    end else if (en) begin
      fv_q[0] <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fst_q[0] <= st6_q;
      fi_q[0]  <= i6_q;
      fnr_q[0] <= {n6_q, 1'b0} + 27'(d6_q) - 27'd1;
      fdv_q[0] <= {d6_q, 1'b0};
      fq_q[0]  <= '0;
    end
  end

  // fraction divider, quotient below 512, one bit per stage from the top
  for (genvar k = 0; k < Div2N; k++) begin : g_div2
    logic [26:0] sh;
    logic        take;
    assign sh   = 27'(fdv_q[k]) << (Div2N - 1 - k);
    assign take = fnr_q[k] >= sh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        fv_q[k+1] <= 1'b0;
      end else if (en) begin
        fv_q[k+1] <= fv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        fst_q[k+1] <= fst_q[k];
        fi_q[k+1]  <= fi_q[k];
        fdv_q[k+1] <= fdv_q[k];
        fnr_q[k+1] <= take ? fnr_q[k] - sh : fnr_q[k];
        fq_q[k+1]  <= {fq_q[k][Div2N-2:0], take};
      end
    end
  end

  // output register: base temperature minus fraction, or range override
  logic signed [14:0] temp_d;
  logic               out_v_q;
  logic signed [14:0] temp_q;
  logic [1:0]         st_q;

  always_comb begin
    case (fst_q[Div2N])
      ntc_lin_pkg::StCold: temp_d = ntc_lin_pkg::ColdCenti;
      ntc_lin_pkg::StHot:  temp_d = ntc_lin_pkg::HotCenti;
      default:             temp_d = 15'(15'(fi_q[Div2N]) * 15'(ntc_lin_pkg::StepCenti)
                                         - 15'(fq_q[Div2N]));
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= fv_q[Div2N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      temp_q <= temp_d;
      st_q   <= fst_q[Div2N];
    end
  end

  assign out_valid_o     = out_v_q;
  assign temp_centideg_o = temp_q;
  assign range_status_o  = st_q;

`ifndef SYNTHESIS
  // cold and hot words carry their fixed temperatures
  a_cold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && range_status_o == ntc_lin_pkg::StCold) |->
      temp_centideg_o == ntc_lin_pkg::ColdCenti)
    else $error("cold word with wrong temperature");
  a_hot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && range_status_o == ntc_lin_pkg::StHot) |->
      temp_centideg_o == ntc_lin_pkg::HotCenti)
    else $error("hot word with wrong temperature");
  // interpolated words stay inside the table span
  a_interp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && range_status_o == ntc_lin_pkg::StInterp) |->
      (temp_centideg_o >= 15'sd0 && temp_centideg_o <= 15'sd15000))
    else $error("interpolated temperature out of span");
  // status code never undefined on a valid word
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> range_status_o <= ntc_lin_pkg::StHot)
    else $error("undefined range status");
`endif

endmodule
